// ===== design/rgb_to_ypbpr_macros.svh =====
// Assertion helpers used by the checker file ryp_checker.sv.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef RGB_TO_YPBPR_MACROS_SVH
`define RGB_TO_YPBPR_MACROS_SVH

// Same-cycle implication.
`define RYP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_ypbpr: same-cycle check failed");

// Next-cycle implication.
`define RYP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_ypbpr: next-cycle check failed");

`endif

// ===== design/ryp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ryp_pkg;

  // Port field width of every sample and result
  localparam int unsigned FIELD_W = 16;

  // Quotient: 16 magnitude bits plus one overflow bit on top
  localparam int unsigned Q_BITS = 16;
  localparam int unsigned QW     = Q_BITS + 1;

  // Common denominator: 15625 * max_sample, < 2^30
  localparam int unsigned DEN_SCALE = 15625;
  localparam int unsigned DEN_W     = 30;
  localparam int unsigned DV_W      = DEN_W + 1;   // 2 * denominator
  localparam int unsigned NUM_W     = DV_W + Q_BITS;

  // Luma numerator is sum * 125 * 4096, doubled for rounding
  localparam int unsigned LUMA_MUL    = 125;
  localparam int unsigned LUMA_SHIFT  = 13;
  // Chroma numerator is sum * 16384, doubled for rounding
  localparam int unsigned CHROMA_SHIFT = 15;

  // BT.601 coefficients, luma in 1e-3, chroma in 32e-6 units
  localparam int unsigned COEF_Y_R  = 299;
  localparam int unsigned COEF_Y_G  = 587;
  localparam int unsigned COEF_Y_B  = 114;
  localparam int unsigned COEF_PB_R = 5273;    // negative
  localparam int unsigned COEF_PB_G = 10352;   // negative
  localparam int unsigned COEF_PB_B = 15625;
  localparam int unsigned COEF_PR_R = 15625;
  localparam int unsigned COEF_PR_G = 13084;   // negative
  localparam int unsigned COEF_PR_B = 2541;    // negative

  localparam logic [QW-1:0] LUMA_MAX = QW'(32768);
  localparam logic [QW-1:0] DIFF_MAX = QW'(16384);

  // Config space
  localparam int unsigned     CFG_AW         = 3;
  localparam logic            REG_MAX_SAMPLE = 1'b0;
  localparam logic [FIELD_W-1:0] MAX_SAMPLE_RST = FIELD_W'(255);

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DV_W-1:0]  dvs_t;
  typedef logic [QW-1:0]    quo_t;

endpackage

`default_nettype wire

// ===== design/ryp_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, overflow bit first.
module ryp_div_lane (
  input  logic          clk,
  input  logic          en,
  input  ryp_pkg::num_t num_i,
  input  ryp_pkg::dvs_t dv_i,
  input  logic          neg_i,
  output ryp_pkg::quo_t quo_o,
  output logic          neg_o
);
  import ryp_pkg::*;

  num_t rem_r [QW-1];
  quo_t quo_r [QW];
  logic neg_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int unsigned K = QW - 1 - j;
    num_t rem_in;
    num_t sub;
    quo_t quo_in;
    quo_t quo_nxt;
    logic neg_in;
    logic ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign neg_in = neg_r[j-1];
    end

    assign sub = NUM_W'(dv_i) << K;
    assign ge  = (rem_in >= sub);

    always_comb begin
      quo_nxt    = quo_in;
      quo_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= quo_nxt;
        neg_r[j] <= neg_in;
      end
    end

    if (j < QW - 1) begin : g_keep
      num_t rem_nxt;
      assign rem_nxt = ge ? (rem_in - sub) : rem_in;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= rem_nxt;
        end
      end
    end
  end

  assign quo_o = quo_r[QW-1];
  assign neg_o = neg_r[QW-1];

endmodule

`default_nettype wire

// ===== design/rgb_to_ypbpr.sv =====
`timescale 1ns / 1ps
`default_nettype none

// BT.601 RGB to Y/Pb/Pr converter. Each item is one pixel (red, green, blue,
// low SAMPLE_BITS bits used); each result is luma (0..32768 = 0.0..1.0) and
// the signed color differences Pb and Pr (-16384..16384 = -0.5..0.5), all
// normalized by the max_sample register (byte address 0, reset 255, 0 acts
// as 1), rounded to nearest with halves away from zero, then saturated.
// Throughput is one item per clock while the skid entry is free. The
// pipeline is mostly the 17-stage restoring divider (one quotient bit
// per stage, shared divisor 31250 * max_sample) behind four stages of
// products, sums, magnitudes and rounding offset, plus the clamp stage.
// A two-entry output buffer lets the pipeline keep taking items while a
// result waits; in_ready drops only once the skid entry is also occupied.
// Write max_sample only while no item is in flight.
module rgb_to_ypbpr #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ryp_pkg::FIELD_W-1:0]       in_red,
  input  logic [ryp_pkg::FIELD_W-1:0]       in_green,
  input  logic [ryp_pkg::FIELD_W-1:0]       in_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ryp_pkg::FIELD_W-1:0]       out_luma,
  output logic signed [ryp_pkg::FIELD_W-1:0] out_blue_diff,
  output logic signed [ryp_pkg::FIELD_W-1:0] out_red_diff,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ryp_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import ryp_pkg::*;

  // Widths that follow the sample width
  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned PY_W = SB + 10;   // luma products and sum
  localparam int unsigned PC_W = SB + 14;   // chroma products, sum magnitude
  localparam int unsigned SC_W = SB + 15;   // signed chroma sum
  localparam int unsigned MY_W = SB + 17;   // luma sum * 125
  // products, sums, magnitudes, numerators, divider, clamp
  localparam int unsigned NSTG = 4 + QW + 1;

  // ---------------------------------------------------------------------
  // Config register and derived denominator
  // ---------------------------------------------------------------------
  logic               cfg_wr;
  logic [FIELD_W-1:0] max_r;
  logic [FIELD_W-1:0] dz;
  logic [DEN_W-1:0]   den_r;
  dvs_t               dv;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_SAMPLE_RST;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_MAX_SAMPLE)) begin
      max_r <= cfg_pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[CFG_AW-1:2] == REG_MAX_SAMPLE) begin
      cfg_prdata = 32'(max_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // Zero denominator acts as 1. User keeps it static in flight; unchecked.
  assign dz = (max_r == '0) ? FIELD_W'(1) : max_r;

  always_ff @(posedge clk) begin
    den_r <= DEN_W'(32'(dz) * 32'(DEN_SCALE));
  end

  assign dv = {den_r, 1'b0};

  // ---------------------------------------------------------------------
  // Pipeline control: one global advance, held only when skid is full
  // ---------------------------------------------------------------------
  logic            pipe_en;
  logic [NSTG-1:0] v_r;
  logic            skid_v_r;

  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (pipe_en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: constant products
  // ---------------------------------------------------------------------
  logic [SB-1:0]   r_s, g_s, b_s;
  logic [PY_W-1:0] py_r [3];
  logic [PC_W-1:0] pb_r [3];
  logic [PC_W-1:0] pr_r [3];

  assign r_s = in_red[SB-1:0];
  assign g_s = in_green[SB-1:0];
  assign b_s = in_blue[SB-1:0];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      py_r[0] <= PY_W'(r_s) * PY_W'(COEF_Y_R);
      py_r[1] <= PY_W'(g_s) * PY_W'(COEF_Y_G);
      py_r[2] <= PY_W'(b_s) * PY_W'(COEF_Y_B);
      pb_r[0] <= PC_W'(r_s) * PC_W'(COEF_PB_R);
      pb_r[1] <= PC_W'(g_s) * PC_W'(COEF_PB_G);
      pb_r[2] <= PC_W'(b_s) * PC_W'(COEF_PB_B);
      pr_r[0] <= PC_W'(r_s) * PC_W'(COEF_PR_R);
      pr_r[1] <= PC_W'(g_s) * PC_W'(COEF_PR_G);
      pr_r[2] <= PC_W'(b_s) * PC_W'(COEF_PR_B);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: matrix sums (luma always non-negative)
  // ---------------------------------------------------------------------
  logic [PY_W-1:0]        sy_r;
  logic signed [SC_W-1:0] sb_r, sr_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sy_r <= py_r[0] + py_r[1] + py_r[2];
      sb_r <= $signed({1'b0, pb_r[2]}) - $signed({1'b0, pb_r[0]})
              - $signed({1'b0, pb_r[1]});
      sr_r <= $signed({1'b0, pr_r[0]}) - $signed({1'b0, pr_r[1]})
              - $signed({1'b0, pr_r[2]});
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: luma scale, chroma sign and magnitude
  // ---------------------------------------------------------------------
  logic signed [SC_W-1:0] ab_nxt, ar_nxt;
  logic [MY_W-1:0]        my_r;
  logic [PC_W-1:0]        mb_r, mr_r;
  logic                   nb2_r, nr2_r;

  assign ab_nxt = sb_r[SC_W-1] ? -sb_r : sb_r;
  assign ar_nxt = sr_r[SC_W-1] ? -sr_r : sr_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      my_r  <= MY_W'(sy_r) * MY_W'(LUMA_MUL);
      mb_r  <= ab_nxt[PC_W-1:0];
      mr_r  <= ar_nxt[PC_W-1:0];
      nb2_r <= sb_r[SC_W-1];
      nr2_r <= sr_r[SC_W-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: rounding numerators 2*m + den
  // ---------------------------------------------------------------------
  num_t ny_r, nb_r, nr_r;
  logic nb3_r, nr3_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ny_r  <= (NUM_W'(my_r) << LUMA_SHIFT) + NUM_W'(den_r);
      nb_r  <= (NUM_W'(mb_r) << CHROMA_SHIFT) + NUM_W'(den_r);
      nr_r  <= (NUM_W'(mr_r) << CHROMA_SHIFT) + NUM_W'(den_r);
      nb3_r <= nb2_r;
      nr3_r <= nr2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Divider lanes, divisor 2*den
  // ---------------------------------------------------------------------
  quo_t qy, qb, qr;
  logic ny_neg, nb_neg, nr_neg;

  ryp_div_lane u_div_y (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (ny_r),
    .dv_i  (dv),
    .neg_i (1'b0),
    .quo_o (qy),
    .neg_o (ny_neg)
  );

  ryp_div_lane u_div_b (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (nb_r),
    .dv_i  (dv),
    .neg_i (nb3_r),
    .quo_o (qb),
    .neg_o (nb_neg)
  );

  ryp_div_lane u_div_r (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (nr_r),
    .dv_i  (dv),
    .neg_i (nr3_r),
    .quo_o (qr),
    .neg_o (nr_neg)
  );

  // ---------------------------------------------------------------------
  // Clamp stage; the top quotient bit flags a quotient of 65536 or more
  // ---------------------------------------------------------------------
  quo_t               qy_m, qb_m, qr_m;
  logic [FIELD_W-1:0] luma_nxt, pb_nxt, pr_nxt;
  logic [FIELD_W-1:0] cy_r, cb_r, cr_r;

  always_comb begin
    qy_m     = ny_neg ? '0 : qy;   // luma sum is never negative
    luma_nxt = (qy_m > LUMA_MAX) ? FIELD_W'(LUMA_MAX) : qy_m[FIELD_W-1:0];
    qb_m     = (qb > DIFF_MAX) ? DIFF_MAX : qb;
    qr_m     = (qr > DIFF_MAX) ? DIFF_MAX : qr;
    pb_nxt   = nb_neg ? FIELD_W'(-qb_m) : qb_m[FIELD_W-1:0];
    pr_nxt   = nr_neg ? FIELD_W'(-qr_m) : qr_m[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cy_r <= luma_nxt;
      cb_r <= pb_nxt;
      cr_r <= pr_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------
  logic               push;
  logic               out_v_r;
  logic [FIELD_W-1:0] oy_r, ob_r, or_r;
  logic [FIELD_W-1:0] ky_r, kb_r, kr_r;

  assign push = pipe_en && v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        oy_r <= ky_r;
        ob_r <= kb_r;
        or_r <= kr_r;
      end else begin
        oy_r <= cy_r;
        ob_r <= cb_r;
        or_r <= cr_r;
      end
    end else if (push) begin
      ky_r <= cy_r;
      kb_r <= cb_r;
      kr_r <= cr_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_luma      = oy_r;
  assign out_blue_diff = $signed(ob_r);
  assign out_red_diff  = $signed(or_r);

endmodule

`default_nettype wire

// ===== design/ryp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_ypbpr_macros.svh"

module ryp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_luma,
  input wire logic [15:0] out_blue_diff,
  input wire logic [15:0] out_red_diff
);

  // A stalled item holds
  `RYP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_luma) && $stable(out_blue_diff) && $stable(out_red_diff))

  // Saturation bounds
  `RYP_ASSERT_NOW(a_luma_range, out_valid, out_luma <= 16'd32768)
  `RYP_ASSERT_NOW(a_pb_range, out_valid, ($signed(out_blue_diff) >= -16'sd16384) && ($signed(out_blue_diff) <= 16'sd16384))
  `RYP_ASSERT_NOW(a_pr_range, out_valid, ($signed(out_red_diff) >= -16'sd16384) && ($signed(out_red_diff) <= 16'sd16384))

  // Input back-pressure only follows an output stall
  `RYP_ASSERT_NOW(a_ready_drop, $fell(in_ready), $past(out_valid && !out_ready))

endmodule

bind rgb_to_ypbpr ryp_checker u_ryp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_luma      (out_luma),
  .out_blue_diff (out_blue_diff),
  .out_red_diff  (out_red_diff)
);

`default_nettype wire

// ===== test/ypbpr_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and register ports of rgb_to_ypbpr, predicts
// each result from the accepted pixel and compares in order.
module ypbpr_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [ryp_pkg::FIELD_W-1:0]        in_red,
  input  logic [ryp_pkg::FIELD_W-1:0]        in_green,
  input  logic [ryp_pkg::FIELD_W-1:0]        in_blue,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [ryp_pkg::FIELD_W-1:0]        out_luma,
  input  logic signed [ryp_pkg::FIELD_W-1:0] out_blue_diff,
  input  logic signed [ryp_pkg::FIELD_W-1:0] out_red_diff,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ryp_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  input  logic [31:0]                        cfg_prdata,
  input  logic                               cfg_pready,
  output int unsigned                        mismatches,
  output int unsigned                        pending,
  output int unsigned                        converted
);

  localparam logic [ryp_pkg::CFG_AW-1:0] MAX_SAMPLE_ADDR =
    ryp_pkg::CFG_AW'(4 * ryp_pkg::REG_MAX_SAMPLE);

  // Fixed-point scales: 32768 is 1.0, coefficients in units of 1e-6
  localparam longint ONE_SCALE = 32768;
  localparam longint COEF_UNIT = 1000000;
  localparam longint LUMA_TOP  = 32768;
  localparam longint DIFF_TOP  = 16384;

  localparam longint Y_R  = 299000;
  localparam longint Y_G  = 587000;
  localparam longint Y_B  = 114000;
  localparam longint PB_R = -168736;
  localparam longint PB_G = -331264;
  localparam longint PB_B = 500000;
  localparam longint PR_R = 500000;
  localparam longint PR_G = -418688;
  localparam longint PR_B = -81312;

  typedef struct {
    logic [ryp_pkg::FIELD_W-1:0]        luma;
    logic signed [ryp_pkg::FIELD_W-1:0] blue_diff;
    logic signed [ryp_pkg::FIELD_W-1:0] red_diff;
  } ypbpr_t;

  ypbpr_t                      ypbpr_q[$];
  ypbpr_t                      want;
  logic [ryp_pkg::FIELD_W-1:0] max_sample_cfg;
  int unsigned                 mismatch_cnt;
  int unsigned                 converted_cnt;

  // sum * 32768 / den, nearest, halves away from zero
  function automatic longint div_nearest(input longint sum, input longint den);
    longint num;
    longint mag;
    longint q;
    num = sum * ONE_SCALE;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic ypbpr_t convert_pixel(input logic [ryp_pkg::FIELD_W-1:0] r,
                                           input logic [ryp_pkg::FIELD_W-1:0] g,
                                           input logic [ryp_pkg::FIELD_W-1:0] b,
                                           input logic [ryp_pkg::FIELD_W-1:0] max_val);
    longint sm;
    longint rv;
    longint gv;
    longint bv;
    longint den;
    ypbpr_t res;
    sm  = (longint'(1) << SAMPLE_BITS) - 1;
    rv  = longint'(r) & sm;
    gv  = longint'(g) & sm;
    bv  = longint'(b) & sm;
    // zero denominator acts as one
    den = ((max_val == '0) ? longint'(1) : longint'(max_val)) * COEF_UNIT;
    res.luma = ryp_pkg::FIELD_W'(saturate(div_nearest(Y_R * rv + Y_G * gv + Y_B * bv, den),
                                          0, LUMA_TOP));
    res.blue_diff = ryp_pkg::FIELD_W'(saturate(div_nearest(PB_R * rv + PB_G * gv + PB_B * bv,
                                                           den), -DIFF_TOP, DIFF_TOP));
    res.red_diff = ryp_pkg::FIELD_W'(saturate(div_nearest(PR_R * rv + PR_G * gv + PR_B * bv,
                                                          den), -DIFF_TOP, DIFF_TOP));
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ypbpr_q.delete();
      max_sample_cfg = ryp_pkg::MAX_SAMPLE_RST;
      mismatch_cnt   = 0;
      converted_cnt  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == MAX_SAMPLE_ADDR) begin
        if (cfg_pwrite) begin
          max_sample_cfg = cfg_pwdata[ryp_pkg::FIELD_W-1:0];
        end else if (cfg_prdata !== {16'b0, max_sample_cfg}) begin
          $error("max_sample readback: expected %0d, got %0d", max_sample_cfg, cfg_prdata);
          mismatch_cnt++;
        end
      end

      if (in_valid && in_ready) begin
        ypbpr_q.push_back(convert_pixel(in_red, in_green, in_blue, max_sample_cfg));
      end

      if (out_valid && out_ready) begin
        if (ypbpr_q.size() == 0) begin
          $error("result with nothing pending: luma %0d blue_diff %0d red_diff %0d",
                 out_luma, out_blue_diff, out_red_diff);
          mismatch_cnt++;
        end else begin
          want = ypbpr_q.pop_front();
          converted_cnt++;
          if (out_luma !== want.luma) begin
            $error("luma: expected %0d, got %0d", want.luma, out_luma);
            mismatch_cnt++;
          end
          if (out_blue_diff !== want.blue_diff) begin
            $error("blue_diff: expected %0d, got %0d", want.blue_diff, out_blue_diff);
            mismatch_cnt++;
          end
          if (out_red_diff !== want.red_diff) begin
            $error("red_diff: expected %0d, got %0d", want.red_diff, out_red_diff);
            mismatch_cnt++;
          end
        end
      end
    end
    mismatches <= mismatch_cnt;
    pending    <= ypbpr_q.size();
    converted  <= converted_cnt;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for rgb_to_ypbpr. All prediction and comparison
// lives in ypbpr_checker; this module only drives ports and decides.
module tb;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 200;   // well past the pipeline depth plus the two output entries
  localparam int unsigned SEG_ITEMS        = 54;    // 3 idle mixes x 4 settings x 54
  localparam int unsigned DRAIN_TAIL       = 40;    // idle tail after the final drain

  localparam logic [ryp_pkg::CFG_AW-1:0] MAX_SAMPLE_ADDR =
    ryp_pkg::CFG_AW'(4 * ryp_pkg::REG_MAX_SAMPLE);

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [ryp_pkg::FIELD_W-1:0]        in_red;
  logic [ryp_pkg::FIELD_W-1:0]        in_green;
  logic [ryp_pkg::FIELD_W-1:0]        in_blue;
  logic                               out_valid;
  logic                               out_ready;
  logic [ryp_pkg::FIELD_W-1:0]        out_luma;
  logic signed [ryp_pkg::FIELD_W-1:0] out_blue_diff;
  logic signed [ryp_pkg::FIELD_W-1:0] out_red_diff;
  logic                               cfg_psel;
  logic                               cfg_penable;
  logic                               cfg_pwrite;
  logic [ryp_pkg::CFG_AW-1:0]         cfg_paddr;
  logic [31:0]                        cfg_pwdata;
  logic [31:0]                        cfg_prdata;
  logic                               cfg_pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned converted;

  // Idle rates in percent; updated per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Long output hold-off: top toggles req, receiver answers with ack
  logic        hold_req;
  logic        hold_ack;
  int unsigned cycle_cnt;
  int unsigned settings_cnt;

  rgb_to_ypbpr i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_luma     (out_luma),
    .out_blue_diff(out_blue_diff),
    .out_red_diff (out_red_diff),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  ypbpr_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_luma     (out_luma),
    .out_blue_diff(out_blue_diff),
    .out_red_diff (out_red_diff),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (mismatches),
    .pending      (pending),
    .converted    (converted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog; a hang is a failure
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_ack  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_ack = hold_req;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One pixel: optional idle gap, then hold valid until accepted.
  // Returns in the step of the accepting edge.
  task automatic send_pixel(input logic [ryp_pkg::FIELD_W-1:0] r,
                            input logic [ryp_pkg::FIELD_W-1:0] g,
                            input logic [ryp_pkg::FIELD_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly in-range samples, plus the range ends, over-range and raw noise
  function automatic logic [ryp_pkg::FIELD_W-1:0] draw_sample(input int unsigned denom);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 70) return ryp_pkg::FIELD_W'($urandom_range(denom, 0));
    if (mode < 80) return ($urandom_range(1) != 0) ? ryp_pkg::FIELD_W'(denom) : '0;
    if (mode < 90) return ryp_pkg::FIELD_W'($urandom_range(65535, denom));
    return ryp_pkg::FIELD_W'($urandom_range(65535, 0));
  endfunction

  task automatic send_random_pixel(input int unsigned max_val);
    int unsigned denom;
    logic [ryp_pkg::FIELD_W-1:0] gray;
    denom = (max_val == 0) ? 1 : max_val;
    // gray pixels should give zero color difference
    if ($urandom_range(9) == 0) begin
      gray = draw_sample(denom);
      send_pixel(gray, gray, gray);
    end else begin
      send_pixel(draw_sample(denom), draw_sample(denom), draw_sample(denom));
    end
  endtask

  // Stop offering and wait until every result is back. The first edge lets
  // the checker's count catch up with the last accepted item.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One APB access to max_sample, write or read; deselects before returning
  task automatic cfg_access(input logic is_write, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= MAX_SAMPLE_ADDR;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_max_sample(input int unsigned max_val);
    cfg_access(1'b1, 32'(max_val));
    cfg_access(1'b0, '0);
    settings_cnt++;
  endtask

  initial begin
    int unsigned seg_max[12];
    int unsigned send_by_phase[3];
    int unsigned recv_by_phase[3];

    in_valid     = 1'b0;
    in_red       = '0;
    in_green     = '0;
    in_blue      = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    hold_req     = 1'b0;
    settings_cnt = 1;   // reset value counts as a setting
    send_by_phase = '{26, 49, 0};
    recv_by_phase = '{49, 26, 0};
    send_idle_pct = send_by_phase[0];
    recv_idle_pct = recv_by_phase[0];

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset denominator 255: black, white, primaries, over-range
    // saturation in every direction, alternating bit patterns
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'd255, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd255, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd255);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555);
    drain();

    // Zero denominator must behave as one
    set_max_sample(0);
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd1, 16'd1, 16'd1);
    send_pixel(16'd1, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd1, 16'd1);
    send_pixel(16'd2, 16'd0, 16'd0);
    drain();

    // Full-scale denominator
    set_max_sample(65535);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'd1, 16'd0, 16'd0);

    // Random part: per idle mix, four denominators including the extremes
    seg_max = '{1, 65535, 255, 1023, 0, 4095, 3, 65534,
                $urandom_range(65535, 1), 1000, 16383, $urandom_range(65535, 1)};
    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 4; seg++) begin
        // sender pauses here until all results are back
        drain();
        send_idle_pct <= send_by_phase[phase];
        recv_idle_pct <= recv_by_phase[phase];
        set_max_sample(seg_max[phase * 4 + seg]);
        // flood the block while the output is held off, so in_ready drops
        if (phase == 2 && seg == 0) hold_req <= ~hold_req;
        repeat (SEG_ITEMS) send_random_pixel(seg_max[phase * 4 + seg]);
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Run covered %0d pixels over %0d max_sample settings (zero, one, full scale),",
             converted, settings_cnt);
    $display("  three idle mixes and a %0d-cycle output hold-off.", LONG_HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
